// ----- design/cfr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the command frame receiver: status codes,
// configuration register indexes, reset values and the chase-mode payload.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  // Field widths
  localparam int BYTE_W      = 8;
  localparam int LIMIT_W     = 16;
  localparam int POS_W       = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int PAYLOAD_N   = 4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_OK        = 2'd1,
    ST_FRAME_ERR = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMEOUT_LIMIT = 2'd0,
    REG_HEADER_BYTE   = 2'd1,
    REG_TRAILER_BYTE  = 2'd2
  } cfg_reg_t;

  // Configuration reset values
  localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 16'd400;
  localparam logic [BYTE_W-1:0]  HEADER_BYTE_RST   = 8'hAA;
  localparam logic [BYTE_W-1:0]  TRAILER_BYTE_RST  = 8'h55;

  // Frame byte positions
  localparam logic [POS_W-1:0] POS_HEADER  = 3'd0;
  localparam logic [POS_W-1:0] POS_FIRST   = 3'd1;
  localparam logic [POS_W-1:0] POS_LAST    = 3'd4;
  localparam logic [POS_W-1:0] POS_TRAILER = 3'd5;

  // Payload that selects chase mode
  localparam logic [BYTE_W-1:0] CHASE_PAYLOAD [PAYLOAD_N] =
    '{8'hBB, 8'hCC, 8'hDD, 8'hEE};

endpackage

`default_nettype wire

// ----- design/cfr_channels.sv -----
// ----------------------------------------------------------------------------
// cfr channels
// Valid/ready channel interfaces for input requests and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [cfr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic                        valid;
  logic                        ready;
  cfr_pkg::status_t            status;
  logic                        chase_mode;
  logic [cfr_pkg::BYTE_W-1:0]  duty_zero;
  logic [cfr_pkg::BYTE_W-1:0]  duty_one;
  logic [cfr_pkg::BYTE_W-1:0]  duty_two;
  logic [cfr_pkg::BYTE_W-1:0]  duty_three;
  logic                        in_frame;

  modport source (output valid, output status, output chase_mode, output duty_zero,
                  output duty_one, output duty_two, output duty_three,
                  output in_frame, input ready);
  modport sink   (input valid, input status, input chase_mode, input duty_zero,
                  input duty_one, input duty_two, input duty_three,
                  input in_frame, output ready);
endinterface

`default_nettype wire

// ----- design/command_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// command_frame_receiver
// Six-byte command frame receiver with timeout ticks, chase-mode detection
// and four latched duty levels.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-----------------------------------
//  in_chan   | in  | valid / ready      | func, rx_byte
//  out_chan  | out | valid / ready      | status, chase_mode, duty_*, in_frame
//  cfg       | in  | cfg_we (no wait)   | cfg_index, cfg_data
//
//  The frame state and the result register are loaded at the edge that
//  accepts a request, so one request per cycle flows unless a result stalls.
//  A request is taken while a result waits as long as out_chan.ready is high;
//  a stalled result holds in its register and stops further requests.
//  Synchronous reset clears frame state, duty levels, mode and the result
//  valid, and restores the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_receiver (
  input  wire logic                               clk,
  input  wire logic                               rst,
  cfr_in_if.sink                                  in_chan,
  cfr_out_if.source                               out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [cfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [cfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic [cfr_pkg::LIMIT_W-1:0] timeout_limit;
  logic [cfr_pkg::BYTE_W-1:0]  header_byte;
  logic [cfr_pkg::BYTE_W-1:0]  trailer_byte;

  // Frame state
  logic [cfr_pkg::POS_W-1:0]   byte_position;
  logic [cfr_pkg::POS_W-1:0]   byte_position_next;
  logic [cfr_pkg::LIMIT_W-1:0] tick_count;
  logic [cfr_pkg::LIMIT_W-1:0] tick_count_next;
  logic [cfr_pkg::LIMIT_W-1:0] tick_inc;
  logic [cfr_pkg::BYTE_W-1:0]  payload_store [cfr_pkg::PAYLOAD_N];
  logic                        payload_we;
  logic [1:0]                  payload_idx;
  logic [cfr_pkg::BYTE_W-1:0]  duty_levels [cfr_pkg::PAYLOAD_N];
  logic                        duty_load;
  logic                        mode_flag;
  logic                        mode_flag_next;
  logic                        chase_match;
  cfr_pkg::status_t            status_next;

  // Result register
  logic                        res_valid;
  cfr_pkg::status_t            res_status;
  logic                        res_chase;
  logic [cfr_pkg::BYTE_W-1:0]  res_duty [cfr_pkg::PAYLOAD_N];
  logic                        res_in_frame;

  logic                        accept;

  // Take a request whenever the result slot is free or being drained
  assign in_chan.ready = !res_valid || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= cfr_pkg::TIMEOUT_LIMIT_RST;
      header_byte   <= cfr_pkg::HEADER_BYTE_RST;
      trailer_byte  <= cfr_pkg::TRAILER_BYTE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfr_pkg::REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data;
        cfr_pkg::REG_HEADER_BYTE:   header_byte   <= cfg_data[cfr_pkg::BYTE_W-1:0];
        cfr_pkg::REG_TRAILER_BYTE:  trailer_byte  <= cfg_data[cfr_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Compare stored payload with the chase pattern
  always_comb begin
    chase_match = 1'b1;
    for (int i = 0; i < cfr_pkg::PAYLOAD_N; i++) begin
      if (payload_store[i] != cfr_pkg::CHASE_PAYLOAD[i]) begin
        chase_match = 1'b0;
      end
    end
  end

  assign payload_idx = 2'(byte_position - cfr_pkg::POS_FIRST);
  assign tick_inc    = tick_count + 16'd1;

  // Work out next frame state and the status for one request
  always_comb begin
    byte_position_next = byte_position;
    tick_count_next    = tick_count;
    payload_we         = 1'b0;
    duty_load          = 1'b0;
    mode_flag_next     = mode_flag;
    status_next        = cfr_pkg::ST_NONE;
    if (!in_chan.func) begin
      case (byte_position)
        cfr_pkg::POS_HEADER: begin
          if (in_chan.rx_byte == header_byte) begin
            byte_position_next = cfr_pkg::POS_FIRST;
          end else begin
            status_next = cfr_pkg::ST_FRAME_ERR;
          end
        end
        3'd1, 3'd2, 3'd3, cfr_pkg::POS_LAST: begin
          payload_we         = 1'b1;
          byte_position_next = byte_position + 3'd1;
        end
        cfr_pkg::POS_TRAILER: begin
          byte_position_next = cfr_pkg::POS_HEADER;
          if (in_chan.rx_byte == trailer_byte) begin
            status_next = cfr_pkg::ST_OK;
            if (chase_match) begin
              mode_flag_next = 1'b1;
            end else begin
              duty_load      = 1'b1;
              mode_flag_next = 1'b0;
            end
          end else begin
            status_next = cfr_pkg::ST_FRAME_ERR;
          end
        end
        default: begin
          byte_position_next = cfr_pkg::POS_HEADER;
          status_next        = cfr_pkg::ST_FRAME_ERR;
        end
      endcase
    end else if (byte_position != cfr_pkg::POS_HEADER) begin
      // Count ticks only inside a frame; abort on reaching the limit
      if (tick_inc == timeout_limit) begin
        tick_count_next    = '0;
        byte_position_next = cfr_pkg::POS_HEADER;
        status_next        = cfr_pkg::ST_TIMEOUT;
      end else begin
        tick_count_next = tick_inc;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= cfr_pkg::POS_HEADER;
      tick_count    <= '0;
      mode_flag     <= 1'b0;
      for (int i = 0; i < cfr_pkg::PAYLOAD_N; i++) begin
        duty_levels[i] <= '0;
      end
    end else if (accept) begin
      byte_position <= byte_position_next;
      tick_count    <= tick_count_next;
      mode_flag     <= mode_flag_next;
      if (duty_load) begin
        for (int i = 0; i < cfr_pkg::PAYLOAD_N; i++) begin
          duty_levels[i] <= payload_store[i];
        end
      end
    end
  end

  // Payload bytes, written as they arrive
  always_ff @(posedge clk) begin
    if (accept && payload_we) begin
      payload_store[payload_idx] <= in_chan.rx_byte;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_chan.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload: load the state after this request
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status   <= status_next;
      res_chase    <= mode_flag_next;
      res_in_frame <= (byte_position_next != cfr_pkg::POS_HEADER);
      for (int i = 0; i < cfr_pkg::PAYLOAD_N; i++) begin
        res_duty[i] <= duty_load ? payload_store[i] : duty_levels[i];
      end
    end
  end

  assign out_chan.valid      = res_valid;
  assign out_chan.status     = res_status;
  assign out_chan.chase_mode = res_chase;
  assign out_chan.duty_zero  = res_duty[0];
  assign out_chan.duty_one   = res_duty[1];
  assign out_chan.duty_two   = res_duty[2];
  assign out_chan.duty_three = res_duty[3];
  assign out_chan.in_frame   = res_in_frame;

  // Position never leaves the six-byte frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= cfr_pkg::POS_TRAILER)
    else $error("byte position out of range");

  // A stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("request taken while result stalled");

  // Tick count moves only on an accepted tick
  a_tick_stable: assert property (@(posedge clk) disable iff (rst)
    !(accept && in_chan.func) |=> $stable(tick_count))
    else $error("tick count changed without a tick");

  // Reported in-frame flag follows the frame position
  a_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_chan.in_frame == (byte_position != cfr_pkg::POS_HEADER)))
    else $error("in_frame does not match position");

  // Any reported event ends the frame
  a_event_ends: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && (out_chan.status == cfr_pkg::ST_OK ||
     out_chan.status == cfr_pkg::ST_FRAME_ERR ||
     out_chan.status == cfr_pkg::ST_TIMEOUT)) |-> !out_chan.in_frame)
    else $error("frame still open after status event");

endmodule

`default_nettype wire
